// File: src/aen_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accept-Encoding negotiator package
// Shared types, constants and character tables for the negotiator.
// ----------------------------------------------------------------------------
package aen_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TokLenW  = 4;
  localparam int unsigned QualW    = 11;
  localparam int unsigned SeenW    = 12;
  localparam int unsigned DecW     = 2;

  localparam logic [QualW-1:0] FullQuality = 11'd1000;
  localparam logic [SeenW-1:0] SeenUnset   = 12'hFFF;

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChSemi  = 8'h3B;
  localparam logic [ByteW-1:0] ChEq    = 8'h3D;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChStar  = 8'h2A;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChOne   = 8'h31;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChLowQ  = 8'h71;
  localparam logic [ByteW-1:0] ChUpQ   = 8'h51;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;

  typedef enum logic [DecW-1:0] {
    DEC_IDENTITY = 2'd0,
    DEC_GZIP     = 2'd1,
    DEC_NONE     = 2'd2
  } decision_e;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic             has_byte;
    logic             last;
  } item_t;

  function automatic logic [ByteW-1:0] gzip_char(input logic [1:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      2'd0:    c = 8'h67;
      2'd1:    c = 8'h7A;
      2'd2:    c = 8'h69;
      default: c = 8'h70;
    endcase
    return c;
  endfunction

  function automatic logic [ByteW-1:0] identity_char(input logic [2:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      3'd0:    c = 8'h69;
      3'd1:    c = 8'h64;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h74;
      3'd5:    c = 8'h69;
      3'd6:    c = 8'h74;
      default: c = 8'h79;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] digit_weight(input logic [1:0] pos);
    logic [6:0] w;
    case (pos)
      2'd0:    w = 7'd100;
      2'd1:    w = 7'd10;
      default: w = 7'd1;
    endcase
    return w;
  endfunction

endpackage

// File: src/accept_encoding_negotiator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accept-Encoding negotiator
// Parses an Accept-Encoding header value byte by byte and picks gzip,
// identity or not acceptable on the final byte.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: header_byte; tuser: has_byte; tlast: last
//   m_axis    out        tdata: decision (bits 1:0, upper bits zero)
//   cfg       in         cfg_data_i: compress_enable
//
// One item is taken every cycle unless a final item waits for room in the
// result register; the byte parser is a combinational state update between
// the input register and the result register. A decision is registered in
// the result register after its last item has passed the input register.
// Reset restores the parser and sets compress_enable to 1.
// ----------------------------------------------------------------------------
module accept_encoding_negotiator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] header_byte
  input  logic       s_axis_tuser,   // [0] has_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] decision, [7:2] zero
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  aen_pkg::item_t     in_item;
  aen_pkg::item_t     stage_item;
  logic               stage_valid;
  logic               pop;
  logic               res_valid;
  logic               out_free;
  aen_pkg::decision_e res_decision;
  aen_pkg::decision_e out_decision;
  logic               compress_enable_q;

  assign in_item.header_byte = s_axis_tdata;
  assign in_item.has_byte    = s_axis_tuser;
  assign in_item.last        = s_axis_tlast;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compress_enable_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      compress_enable_q <= cfg_data_i;
    end
  end

  aen_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .pop_i      (pop),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  aen_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (stage_valid),
    .item_i            (stage_item),
    .out_free_i        (out_free),
    .compress_enable_i (compress_enable_q),
    .pop_o             (pop),
    .res_valid_o       (res_valid),
    .decision_o        (res_decision)
  );

  aen_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .decision_i (res_decision),
    .free_o     (out_free),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .decision_o (out_decision)
  );

  assign m_axis_tdata = {6'b000000, out_decision};

endmodule

// File: src/aen_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Negotiator input register
// Holds one incoming item and refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module aen_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aen_pkg::item_t in_item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output aen_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  aen_pkg::item_t item_q;

  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (pop_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/aen_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Negotiator parser
// Advances the element parser by one byte and forms the decision on the
// final byte of a header value.
// ----------------------------------------------------------------------------
module aen_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  aen_pkg::item_t      item_i,
  input  logic                out_free_i,
  input  logic                compress_enable_i,
  output logic                pop_o,
  output logic                res_valid_o,
  output aen_pkg::decision_e  decision_o
);

  typedef enum logic [3:0] {
    PH_SKIP        = 4'd0,
    PH_TOKEN       = 4'd1,
    PH_AFTER_TOKEN = 4'd2,
    PH_AFTER_SEMI  = 4'd3,
    PH_EXPECT_EQ   = 4'd4,
    PH_Q_FIRST     = 4'd5,
    PH_Q_DOT       = 4'd6,
    PH_Q_DIGITS    = 4'd7,
    PH_TRAIL       = 4'd8,
    PH_JUNK        = 4'd9
  } phase_e;

  phase_e                              phase_q, phase_d;
  logic [aen_pkg::TokLenW-1:0]         tok_len_q, tok_len_d;
  logic [2:0]                          flags_q, flags_d;
  logic [aen_pkg::QualW-1:0]           qual_q, qual_d;
  logic [1:0]                          dpos_q, dpos_d;
  logic signed [aen_pkg::SeenW-1:0]    gz_q, gz_d;
  logic signed [aen_pkg::SeenW-1:0]    id_q, id_d;
  logic signed [aen_pkg::SeenW-1:0]    wc_q, wc_d;
  aen_pkg::decision_e                  decision;

  assign pop_o       = item_valid_i && (!item_i.last || out_free_i);
  assign res_valid_o = pop_o && item_i.last;
  assign decision_o  = decision;

  always_comb begin
    logic [aen_pkg::ByteW-1:0]      b;
    logic [aen_pkg::ByteW-1:0]      lc;
    logic                           ws;
    logic                           skip_byte;
    logic                           finish;
    logic signed [aen_pkg::SeenW-1:0] qual_s;
    logic signed [aen_pkg::SeenW-1:0] gz_eff;

    b         = item_i.header_byte;
    lc        = (b >= aen_pkg::ChUpA && b <= aen_pkg::ChUpZ) ? b + 8'd32 : b;
    ws        = (b == aen_pkg::ChSpace) || (b >= aen_pkg::ChTab && b <= aen_pkg::ChCr);
    skip_byte = 1'b0;
    finish    = 1'b0;

    phase_d   = phase_q;
    tok_len_d = tok_len_q;
    flags_d   = flags_q;
    qual_d    = qual_q;
    dpos_d    = dpos_q;
    gz_d      = gz_q;
    id_d      = id_q;
    wc_d      = wc_q;

    if (item_i.has_byte) begin
      if (phase_d == PH_SKIP) begin
        if (b == aen_pkg::ChSpace || b == aen_pkg::ChTab || b == aen_pkg::ChComma) begin
          skip_byte = 1'b1;
        end else begin
          phase_d = PH_TOKEN;
        end
      end
      if (!skip_byte) begin
        if (b == aen_pkg::ChComma) begin
          finish = 1'b1;
        end else begin
          case (phase_d)
            PH_TOKEN: begin
              if (b == aen_pkg::ChSemi) begin
                qual_d  = '0;
                phase_d = PH_AFTER_SEMI;
              end else if (ws) begin
                phase_d = PH_AFTER_TOKEN;
              end else begin
                if (tok_len_q >= 4'd4 || lc != aen_pkg::gzip_char(tok_len_q[1:0])) begin
                  flags_d[0] = 1'b0;
                end
                if (tok_len_q >= 4'd8 || lc != aen_pkg::identity_char(tok_len_q[2:0])) begin
                  flags_d[1] = 1'b0;
                end
                if (tok_len_q >= 4'd1 || b != aen_pkg::ChStar) begin
                  flags_d[2] = 1'b0;
                end
                if (tok_len_q != 4'd15) begin
                  tok_len_d = tok_len_q + 4'd1;
                end
              end
            end
            PH_AFTER_TOKEN: begin
              if (b == aen_pkg::ChSemi) begin
                qual_d  = '0;
                phase_d = PH_AFTER_SEMI;
              end else if (!ws) begin
                qual_d  = '0;
                phase_d = PH_JUNK;
              end
            end
            PH_AFTER_SEMI: begin
              if (b == aen_pkg::ChLowQ || b == aen_pkg::ChUpQ) begin
                phase_d = PH_EXPECT_EQ;
              end else if (!ws) begin
                qual_d  = '0;
                phase_d = PH_JUNK;
              end
            end
            PH_EXPECT_EQ: begin
              if (b == aen_pkg::ChEq) begin
                phase_d = PH_Q_FIRST;
              end else begin
                qual_d  = '0;
                phase_d = PH_JUNK;
              end
            end
            PH_Q_FIRST: begin
              if (b == aen_pkg::ChZero || b == aen_pkg::ChOne) begin
                qual_d  = (b == aen_pkg::ChOne) ? aen_pkg::FullQuality : '0;
                phase_d = PH_Q_DOT;
              end else begin
                qual_d  = '0;
                phase_d = PH_JUNK;
              end
            end
            PH_Q_DOT: begin
              if (b == aen_pkg::ChDot) begin
                phase_d = PH_Q_DIGITS;
              end else if (ws) begin
                phase_d = PH_TRAIL;
              end else begin
                qual_d  = '0;
                phase_d = PH_JUNK;
              end
            end
            PH_Q_DIGITS: begin
              if (b >= aen_pkg::ChZero && b <= aen_pkg::ChNine) begin
                if (dpos_q == 2'd3 ||
                    (qual_q >= aen_pkg::FullQuality && b != aen_pkg::ChZero)) begin
                  qual_d  = '0;
                  phase_d = PH_JUNK;
                end else begin
                  qual_d = qual_q + aen_pkg::QualW'(b[3:0] * aen_pkg::digit_weight(dpos_q));
                  dpos_d = dpos_q + 2'd1;
                end
              end else if (ws) begin
                phase_d = PH_TRAIL;
              end else begin
                qual_d  = '0;
                phase_d = PH_JUNK;
              end
            end
            PH_TRAIL: begin
              if (!ws) begin
                qual_d  = '0;
                phase_d = PH_JUNK;
              end
            end
            default: begin
              qual_d  = '0;
              phase_d = PH_JUNK;
            end
          endcase
        end
      end
    end

    if (item_i.last && phase_d != PH_SKIP) begin
      finish = 1'b1;
    end

    qual_s = $signed({1'b0, qual_d});
    if (finish) begin
      if (tok_len_d == 4'd4 && flags_d[0]) begin
        gz_d = qual_s;
      end else if (tok_len_d == 4'd8 && flags_d[1]) begin
        id_d = qual_s;
      end else if (tok_len_d == 4'd1 && flags_d[2]) begin
        wc_d = qual_s;
      end
      phase_d   = PH_SKIP;
      tok_len_d = '0;
      flags_d   = 3'b111;
      qual_d    = aen_pkg::FullQuality;
      dpos_d    = '0;
    end

    gz_eff = (gz_d < 0) ? wc_d : gz_d;
    if (compress_enable_i && gz_eff > 0 && gz_eff >= id_d) begin
      decision = aen_pkg::DEC_GZIP;
    end else if (id_d == 0 || (id_d < 0 && wc_d == 0)) begin
      decision = aen_pkg::DEC_NONE;
    end else begin
      decision = aen_pkg::DEC_IDENTITY;
    end

    if (item_i.last) begin
      gz_d = $signed(aen_pkg::SeenUnset);
      id_d = $signed(aen_pkg::SeenUnset);
      wc_d = $signed(aen_pkg::SeenUnset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SKIP;
      tok_len_q <= '0;
      flags_q   <= 3'b111;
      qual_q    <= aen_pkg::FullQuality;
      dpos_q    <= '0;
      gz_q      <= $signed(aen_pkg::SeenUnset);
      id_q      <= $signed(aen_pkg::SeenUnset);
      wc_q      <= $signed(aen_pkg::SeenUnset);
    end else if (pop_o) begin
      phase_q   <= phase_d;
      tok_len_q <= tok_len_d;
      flags_q   <= flags_d;
      qual_q    <= qual_d;
      dpos_q    <= dpos_d;
      gz_q      <= gz_d;
      id_q      <= id_d;
      wc_q      <= wc_d;
    end
  end

endmodule

// File: src/aen_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Negotiator result register
// Holds one decision until the downstream side takes it.
// ----------------------------------------------------------------------------
module aen_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  aen_pkg::decision_e decision_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output aen_pkg::decision_e decision_o
);

  logic               valid_q;
  aen_pkg::decision_e decision_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      decision_q <= decision_i;
    end
  end

  assign valid_o    = valid_q;
  assign decision_o = decision_q;

endmodule
